FILE: design/mfev_pkg.sv
// Package with the constants, types and codes of the free-edge vertex counter.
package mfev_pkg;

  localparam int unsigned VertexBits = 14;
  localparam int unsigned MaxVertices = 16384;
  localparam int unsigned EdgeSlots = 65536;
  localparam int unsigned SlotBits = 16;
  localparam int unsigned CountBits = 18;
  localparam int unsigned KeyBits = 2 * VertexBits;
  localparam int unsigned EntryBits = KeyBits + 2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  typedef logic [VertexBits-1:0] vertex_t;
  typedef logic [CountBits-1:0] count_t;

  typedef struct packed {
    logic [1:0] op;
    vertex_t    vertex_a;
    vertex_t    vertex_b;
    vertex_t    vertex_c;
  } in_item_t;

  typedef struct packed {
    vertex_t vertex_index;
    count_t  free_edge_count;
    logic    non_manifold;
    logic    table_overflow;
  } out_item_t;

endpackage

FILE: design/mfev_if.sv
// Valid/ready channel interface carrying one item.
interface mfev_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: design/mfev_ram.sv
// Generic single-port RAM with a registered read.
module mfev_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: design/mesh_free_edge_vertex_counter.sv
// Top level of the free-edge vertex counter: sequencer, edge table and vertex counters.
//
// Usage: items enter on the in_ channel (op, vertex_a, vertex_b, vertex_c).
// An add-face item inserts its three undirected edges into an open-addressed
// edge table held in a 65536-entry RAM; each 0->1 or 1->2 count change moves
// the free-edge counters (a 16384-entry RAM) of both endpoints up or down.
// A query item returns one item on the out_ channel with the vertex's count,
// the non-manifold flag (count >= the cfg_ threshold) and the sticky overflow flag.
// A clear item empties both RAMs by a sweep over every edge slot.
// Steps: a query reads its counter in ST_QRD and ST_QWAIT, and ST_QOUT
// registers the result. A face takes, per edge, the setup states ST_EDGE and
// ST_HASH, ST_PROBE and ST_CHECK for each probed slot and, on a count change, a
// counter read-modify-write (ST_VRD, ST_VWAIT, ST_VWR) for each endpoint, one
// after another, since the RAMs are single-port. One item is worked on at a time.
// After reset a clearing pass over every edge slot runs before any item is taken;
// configuration writes on cfg_ are taken at any time.
// A stalled receiver holds the result in the output register; the block
// takes no new item until that result is gone.
module mesh_free_edge_vertex_counter
  import mfev_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  mfev_if.sink        in_ch,
  mfev_if.source      out_ch
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_EDGE  = 4'd2;
  localparam logic [3:0] ST_HASH  = 4'd3;
  localparam logic [3:0] ST_PROBE = 4'd4;
  localparam logic [3:0] ST_CHECK = 4'd5;
  localparam logic [3:0] ST_VRD   = 4'd6;
  localparam logic [3:0] ST_VWAIT = 4'd7;
  localparam logic [3:0] ST_VWR   = 4'd8;
  localparam logic [3:0] ST_QRD   = 4'd9;
  localparam logic [3:0] ST_QWAIT = 4'd10;
  localparam logic [3:0] ST_QOUT  = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [7:0] thresh_r;
  in_item_t item_r;
  logic [1:0] edge_idx_r;          // which edge of the face
  vertex_t lo_r, hi_r;
  logic [SlotBits-1:0] slot_r;
  logic [SlotBits:0] probes_r;     // probes made, up to EdgeSlots
  logic up_r;                      // direction of counter change
  logic end_r;                     // which endpoint: 0 lo, 1 hi
  logic ovf_r;
  logic [SlotBits:0] clr_r;
  logic [SlotBits-1:0] hash_lo_r, hash_hi_r;
  out_item_t out_r;
  logic out_valid_r;

  // Edge RAM.
  logic et_we;
  logic [SlotBits-1:0] et_addr;
  logic [EntryBits-1:0] et_wdata, et_rdata;
  // Vertex RAM.
  logic vc_we;
  vertex_t vc_addr;
  count_t vc_wdata, vc_rdata;

  mfev_ram #(.Width(EntryBits), .Depth(EdgeSlots)) u_edge_ram (
    .clk(clk), .we(et_we), .addr(et_addr), .wdata(et_wdata), .rdata(et_rdata)
  );
  mfev_ram #(.Width(CountBits), .Depth(MaxVertices)) u_vert_ram (
    .clk(clk), .we(vc_we), .addr(vc_addr), .wdata(vc_wdata), .rdata(vc_rdata)
  );

  // Endpoints of the current edge in face order (a,b), (b,c), (c,a).
  vertex_t ep, eq;
  always_comb begin
    unique case (edge_idx_r)
      2'd0:    begin ep = item_r.vertex_a; eq = item_r.vertex_b; end
      2'd1:    begin ep = item_r.vertex_b; eq = item_r.vertex_c; end
      default: begin ep = item_r.vertex_c; eq = item_r.vertex_a; end
    endcase
  end

  logic [KeyBits-1:0] key;
  logic [1:0] slot_cnt;
  logic slot_hit;
  assign key = {hi_r, lo_r};
  assign slot_cnt = et_rdata[EntryBits-1 -: 2];
  assign slot_hit = et_rdata[KeyBits-1:0] == key;

  // Home slot of the edge: the hash modulo the table size is its low bits.
  logic [SlotBits-1:0] home_slot;
  assign home_slot = hash_lo_r + hash_hi_r;

  assign cfg_ready = 1'b1;
  assign in_ch.ready = (state_r == ST_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_r;

  logic in_fire;
  assign in_fire = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt = state_r;
    et_we = 1'b0;
    et_addr = slot_r;
    et_wdata = '0;
    vc_we = 1'b0;
    vc_addr = end_r ? hi_r : lo_r;
    vc_wdata = vc_rdata;
    unique case (state_r)
      ST_CLEAR: begin
        et_we = 1'b1;
        et_addr = clr_r[SlotBits-1:0];
        vc_we = 1'b1;
        vc_addr = clr_r[VertexBits-1:0];
        vc_wdata = '0;
        if (clr_r == (SlotBits+1)'(EdgeSlots - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.data.op)
            OP_ADD:   state_nxt = ST_EDGE;
            OP_QUERY: state_nxt = ST_QRD;
            OP_CLEAR: state_nxt = ST_CLEAR;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_EDGE:  state_nxt = ST_HASH;
      ST_HASH:  state_nxt = ST_PROBE;
      ST_PROBE: begin
        // The first probe reads the home slot straight from the hash.
        if (probes_r == '0) et_addr = home_slot;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (slot_cnt == 2'd0) begin
          et_we = 1'b1;
          et_wdata = {2'd1, key};
          state_nxt = ST_VRD;
        end else if (slot_hit) begin
          if (slot_cnt == 2'd1) begin
            et_we = 1'b1;
            et_wdata = {2'd2, key};
            state_nxt = ST_VRD;
          end else begin
            state_nxt = (edge_idx_r == 2'd2) ? ST_IDLE : ST_EDGE;
          end
        end else if (probes_r == (SlotBits+1)'(EdgeSlots)) begin
          state_nxt = (edge_idx_r == 2'd2) ? ST_IDLE : ST_EDGE;
        end else begin
          et_addr = slot_r;
          state_nxt = ST_PROBE;
        end
      end
      ST_VRD:   state_nxt = ST_VWAIT;
      ST_VWAIT: state_nxt = ST_VWR;
      ST_VWR: begin
        vc_we = 1'b1;
        if (up_r) vc_wdata = (vc_rdata == CountMax) ? vc_rdata : vc_rdata + 1'b1;
        else vc_wdata = (vc_rdata == '0) ? vc_rdata : vc_rdata - 1'b1;
        if (!end_r) state_nxt = ST_VRD;
        else state_nxt = (edge_idx_r == 2'd2) ? ST_IDLE : ST_EDGE;
      end
      ST_QRD: begin
        vc_addr = item_r.vertex_a;
        state_nxt = ST_QWAIT;
      end
      ST_QWAIT: begin
        vc_addr = item_r.vertex_a;
        state_nxt = ST_QOUT;
      end
      ST_QOUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      thresh_r <= 8'd4;
      ovf_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) thresh_r <= cfg_data;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: clr_r <= clr_r + 1'b1;
        ST_IDLE: begin
          if (in_fire) begin
            item_r <= in_ch.data;
            edge_idx_r <= 2'd0;
            clr_r <= '0;
            if (in_ch.data.op == OP_CLEAR) ovf_r <= 1'b0;
          end
        end
        ST_EDGE: begin
          lo_r <= (ep < eq) ? ep : eq;
          hi_r <= (ep < eq) ? eq : ep;
          probes_r <= '0;
          end_r <= 1'b0;
        end
        ST_HASH: begin
          hash_lo_r <= SlotBits'(32'(lo_r) * 32'd40503);
          hash_hi_r <= SlotBits'(32'(hi_r) * 32'd2654435761);
        end
        ST_PROBE: begin
          if (probes_r == '0) slot_r <= home_slot;
        end
        ST_CHECK: begin
          if (slot_cnt == 2'd0) begin
            up_r <= 1'b1;
          end else if (slot_hit) begin
            up_r <= 1'b0;
            if (slot_cnt != 2'd1) edge_idx_r <= edge_idx_r + 1'b1;
          end else if (probes_r == (SlotBits+1)'(EdgeSlots)) begin
            ovf_r <= 1'b1;
            edge_idx_r <= edge_idx_r + 1'b1;
          end else begin
            slot_r <= slot_r + 1'b1;
            probes_r <= probes_r + 1'b1;
          end
        end
        ST_VWR: begin
          end_r <= ~end_r;
          if (end_r) edge_idx_r <= edge_idx_r + 1'b1;
        end
        ST_QOUT: begin
          out_r.vertex_index <= item_r.vertex_a;
          out_r.free_edge_count <= vc_rdata;
          out_r.non_manifold <= vc_rdata >= count_t'(thresh_r);
          out_r.table_overflow <= ovf_r;
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule
